@@ rtl/assert_macros.svh @@
// Assertion macros shared by the priority queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication check, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/sprq_pkg.sv @@
// Shared types and defaults for the stable priority queue.
// No dependencies; used by the controller, datapath and top level.
package sprq_pkg;

	// Default configuration
	localparam int CAPACITY     = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int PRIORITY_BITS = 16;

	// Input action codes
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DEQ_RD,
		ST_DEQ_TAKE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_HEAD_RD,
		ST_LOAD
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture_in;  // latch request, reset per-item flags
		logic set_rej;     // mark enqueue as rejected
		logic rd_head;     // read logical slot 0
		logic rd_prev;     // read logical slot k-1
		logic do_deq;      // take head payload, advance head, count down
		logic shift_wr;    // move read entry to slot k, k down
		logic ins_wr;      // write new entry at slot k, count up
		logic load_out;    // load output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic action;      // latched action code
		logic empty;
		logic full;
		logic k_one;       // insertion slot is logical 1
		logic greater;     // read entry priority above request priority
	} sts_t;

endpackage

@@ rtl/sprq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/sprq_ctrl.sv @@
// Controller state machine of the priority queue: sequences one transaction.
// Depends on sprq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sprq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  sprq_pkg::sts_t  sts,
	output sprq_pkg::cmd_t  cmd
);

	sprq_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sprq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sprq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture_in = 1'b1;
					state_d        = sprq_pkg::ST_DECODE;
				end
			end
			sprq_pkg::ST_DECODE: begin
				if (sts.action == sprq_pkg::ACT_DEQ) begin
					state_d = sts.empty ? sprq_pkg::ST_HEAD_RD : sprq_pkg::ST_DEQ_RD;
				end else if (sts.full) begin
					cmd.set_rej = 1'b1;
					state_d     = sprq_pkg::ST_HEAD_RD;
				end else if (sts.empty) begin
					state_d = sprq_pkg::ST_INS_WR;
				end else begin
					state_d = sprq_pkg::ST_INS_RD;
				end
			end
			sprq_pkg::ST_DEQ_RD: begin
				cmd.rd_head = 1'b1;
				state_d     = sprq_pkg::ST_DEQ_TAKE;
			end
			sprq_pkg::ST_DEQ_TAKE: begin
				cmd.do_deq = 1'b1;
				state_d    = sprq_pkg::ST_HEAD_RD;
			end
			sprq_pkg::ST_INS_RD: begin
				cmd.rd_prev = 1'b1;
				state_d     = sprq_pkg::ST_INS_CMP;
			end
			sprq_pkg::ST_INS_CMP: begin
				// strictly greater moves up; ties stay ahead of the new entry
				if (sts.greater) begin
					cmd.shift_wr = 1'b1;
					state_d      = sts.k_one ? sprq_pkg::ST_INS_WR : sprq_pkg::ST_INS_RD;
				end else begin
					cmd.ins_wr = 1'b1;
					state_d    = sprq_pkg::ST_HEAD_RD;
				end
			end
			sprq_pkg::ST_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = sprq_pkg::ST_HEAD_RD;
			end
			sprq_pkg::ST_HEAD_RD: begin
				// read the head once all writes of the step are done
				cmd.rd_head = 1'b1;
				state_d     = sprq_pkg::ST_LOAD;
			end
			sprq_pkg::ST_LOAD: begin
				// head data waits in the RAM read register
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sprq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sprq_pkg::ST_IDLE;
			end
		endcase
	end

	`SPQ_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_q || out_ready, "output overwritten")
	`SPQ_ASSERT_IMP(a_cmp_after_rd, state_q == sprq_pkg::ST_INS_CMP, $past(state_q) == sprq_pkg::ST_INS_RD, "compare without read")
	`SPQ_ASSERT_IMP(a_one_load, cmd.load_out, $past(state_q) != sprq_pkg::ST_IDLE, "load right after accept")

endmodule

@@ rtl/sprq_dp.sv @@
// Datapath of the priority queue: circular sorted store, counters and result registers.
// Depends on sprq_pkg, sprq_ram and assert_macros.svh.
`include "assert_macros.svh"

module sprq_dp #(
	parameter int CAPACITY      = sprq_pkg::CAPACITY,
	parameter int PAYLOAD_BITS  = sprq_pkg::PAYLOAD_BITS,
	parameter int PRIORITY_BITS = sprq_pkg::PRIORITY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sprq_pkg::cmd_t                   cmd,
	output sprq_pkg::sts_t                   sts,
	input  logic                             action,
	input  logic [PRIORITY_BITS-1:0]         priority_req,
	input  logic [PAYLOAD_BITS-1:0]          payload,
	output logic                             taken_valid,
	output logic [PAYLOAD_BITS-1:0]          taken_payload,
	output logic                             head_valid,
	output logic [PAYLOAD_BITS-1:0]          head_payload,
	output logic [PRIORITY_BITS-1:0]         head_priority,
	output logic [$clog2(CAPACITY+1)-1:0]    entry_count,
	output logic                             rejected
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = PRIORITY_BITS + PAYLOAD_BITS;
	localparam logic [AW:0]   CAP_SUM = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);

	// Queue state
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] k_m1;

	// Latched request and per-transaction flags
	logic                     req_action_q;
	logic [PRIORITY_BITS-1:0] req_prio_q;
	logic [PAYLOAD_BITS-1:0]  req_payload_q;
	logic                     tk_valid_q;
	logic [PAYLOAD_BITS-1:0]  tk_payload_q;
	logic                     rej_q;

	// RAM signals
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [WW-1:0]            wr_data;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [WW-1:0]            rd_data;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [PAYLOAD_BITS-1:0]  rd_payload;

	// Logical slot to physical address, modulo capacity
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] j);
		logic [AW:0] sum;
		sum = {1'b0, hd} + {1'b0, j};
		if (sum >= CAP_SUM) begin
			sum = sum - CAP_SUM;
		end
		return sum[AW-1:0];
	endfunction

	assign k_m1       = k_q - 1'b1;
	assign rd_prio    = rd_data[WW-1:PAYLOAD_BITS];
	assign rd_payload = rd_data[PAYLOAD_BITS-1:0];

	// Store access
	assign wr_en   = cmd.shift_wr || cmd.ins_wr;
	assign wr_addr = phys(head_q, k_q[AW-1:0]);
	assign wr_data = cmd.shift_wr ? rd_data : {req_prio_q, req_payload_q};
	assign rd_en   = cmd.rd_head || cmd.rd_prev;
	assign rd_addr = cmd.rd_head ? head_q : phys(head_q, k_m1[AW-1:0]);

	sprq_ram #(
		.WIDTH(WW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Status to controller
	assign sts.action  = req_action_q;
	assign sts.empty   = (count_q == '0);
	assign sts.full    = (count_q == CAP_CNT);
	assign sts.k_one   = (k_q == CW'(1));
	assign sts.greater = (rd_prio > req_prio_q);

	// Count and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else begin
			if (cmd.do_deq) begin
				count_q <= count_q - 1'b1;
				head_q  <= (head_q == LAST) ? '0 : head_q + 1'b1;
			end else if (cmd.ins_wr) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Request latch and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			req_action_q  <= action;
			req_prio_q    <= priority_req;
			req_payload_q <= payload;
			k_q           <= count_q;
			tk_valid_q    <= 1'b0;
			tk_payload_q  <= '0;
			rej_q         <= 1'b0;
		end else begin
			if (cmd.set_rej) begin
				rej_q <= 1'b1;
			end
			if (cmd.do_deq) begin
				tk_valid_q   <= 1'b1;
				tk_payload_q <= rd_payload;
			end
			if (cmd.shift_wr) begin
				k_q <= k_m1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			taken_valid   <= tk_valid_q;
			taken_payload <= tk_payload_q;
			rejected      <= rej_q;
			entry_count   <= count_q;
			head_valid    <= !sts.empty;
			head_payload  <= sts.empty ? '0 : rd_payload;
			head_priority <= sts.empty ? '0 : rd_prio;
		end
	end

	`SPQ_ASSERT(a_count_range, count_q <= CAP_CNT, "count above capacity")
	`SPQ_ASSERT_IMP(a_ins_room, cmd.ins_wr, count_q < CAP_CNT, "insert into full store")
	`SPQ_ASSERT_IMP(a_deq_held, cmd.do_deq, count_q != '0, "dequeue from empty store")

endmodule

@@ rtl/stable_priority_queue_unit.sv @@
// Stable priority queue: lower priority number served first, ties leave in FIFO order.
//
// Input channel (in_valid/in_ready): action selects enqueue of priority_req with
// payload, or dequeue of the head. One transaction is processed at a time; in_ready
// is high only while the controller is idle.
// Output channel (out_valid/out_ready): one result per input transaction with the
// dequeued payload, head after the step, entry count and rejected flag.
// Every transaction ends by reading the head back and loading the result; an enqueue
// that is not rejected first moves each held entry of greater priority up one slot.
// The store is a single-port-write, single-port-read RAM used as a circular buffer;
// a dequeue only advances the head pointer, while an enqueue walks from the tail
// toward the head, one moved entry at a time (read, then compare and write).
// A new transaction can be accepted in the cycle after the result is loaded, so a result
// may still wait in the output register while the next item is processed.
// If the receiver stalls, the controller holds the finished item until the output
// register frees. Reset (arst_n low) empties the queue; store contents are not cleared.
// Depends on sprq_pkg, sprq_ctrl, sprq_dp and sprq_ram.
module stable_priority_queue_unit #(
	parameter int CAPACITY      = sprq_pkg::CAPACITY,
	parameter int PAYLOAD_BITS  = sprq_pkg::PAYLOAD_BITS,
	parameter int PRIORITY_BITS = sprq_pkg::PRIORITY_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [PRIORITY_BITS-1:0]      priority_req,
	input  logic [PAYLOAD_BITS-1:0]       payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          taken_valid,
	output logic [PAYLOAD_BITS-1:0]       taken_payload,
	output logic                          head_valid,
	output logic [PAYLOAD_BITS-1:0]       head_payload,
	output logic [PRIORITY_BITS-1:0]      head_priority,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                          rejected
);

	sprq_pkg::cmd_t cmd;
	sprq_pkg::sts_t sts;

	// Transaction sequencer
	sprq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store, counters and result registers
	sprq_dp #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_BITS  (PAYLOAD_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.priority_req  (priority_req),
		.payload       (payload),
		.taken_valid   (taken_valid),
		.taken_payload (taken_payload),
		.head_valid    (head_valid),
		.head_payload  (head_payload),
		.head_priority (head_priority),
		.entry_count   (entry_count),
		.rejected      (rejected)
	);

endmodule

@@ test/spq_result_checker.sv @@
// Result checker for the stable priority queue: predicts each result from the
// accepted requests and compares it with what the unit returns.
// Depends on sprq_pkg for the widths, the capacity and the action codes.
module spq_result_checker
	import sprq_pkg::*;
(
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 action,
	input  logic [PRIORITY_BITS-1:0]             priority_req,
	input  logic [PAYLOAD_BITS-1:0]              payload,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 taken_valid,
	input  logic [PAYLOAD_BITS-1:0]              taken_payload,
	input  logic                                 head_valid,
	input  logic [PAYLOAD_BITS-1:0]              head_payload,
	input  logic [PRIORITY_BITS-1:0]             head_priority,
	input  logic [$clog2(CAPACITY+1)-1:0]        entry_count,
	input  logic                                 rejected,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   requests,
	output int                                   checked,
	output int                                   full_rejects,
	output int                                   empty_deqs,
	output int                                   peak_fill
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic                     taken_valid;
		logic [PAYLOAD_BITS-1:0]  taken_payload;
		logic                     head_valid;
		logic [PAYLOAD_BITS-1:0]  head_payload;
		logic [PRIORITY_BITS-1:0] head_priority;
		logic [CNT_BITS-1:0]      entry_count;
		logic                     rejected;
	} queue_outcome_t;

	// Shadow copy of the sorted store, slot 0 is the head
	logic [PRIORITY_BITS-1:0] ord_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  ord_data [CAPACITY];
	int                       fill;
	int                       slot;
	int                       idx;
	queue_outcome_t           want;
	queue_outcome_t           outcomes[$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		requests     = 0;
		checked      = 0;
		full_rejects = 0;
		empty_deqs   = 0;
		peak_fill    = 0;
	end

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] got_val);
		if (got_val !== exp_val) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			outcomes.delete();
			pending = 0;
		end else begin
			// Predict the outcome of an accepted request transaction
			if (in_valid && in_ready) begin
				requests++;
				want = '0;
				if (action == ACT_ENQ) begin
					if (fill >= CAPACITY) begin
						want.rejected = 1'b1;
						full_rejects++;
					end else begin
						// ties go behind the entries already held at that priority
						slot = 0;
						while (slot < fill && ord_prio[slot] <= priority_req)
							slot++;
						for (idx = fill; idx > slot; idx--) begin
							ord_prio[idx] = ord_prio[idx-1];
							ord_data[idx] = ord_data[idx-1];
						end
						ord_prio[slot] = priority_req;
						ord_data[slot] = payload;
						fill++;
						if (fill > peak_fill)
							peak_fill = fill;
					end
				end else if (fill > 0) begin
					want.taken_valid   = 1'b1;
					want.taken_payload = ord_data[0];
					for (idx = 0; idx + 1 < fill; idx++) begin
						ord_prio[idx] = ord_prio[idx+1];
						ord_data[idx] = ord_data[idx+1];
					end
					fill--;
				end else begin
					empty_deqs++;
				end
				if (fill > 0) begin
					want.head_valid    = 1'b1;
					want.head_payload  = ord_data[0];
					want.head_priority = ord_prio[0];
				end
				want.entry_count = fill[CNT_BITS-1:0];
				outcomes.push_back(want);
			end

			// Compare a result transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (outcomes.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual count %0d",
						$time, entry_count);
				end else begin
					want = outcomes.pop_front();
					checked++;
					check_field("taken_valid", 64'(want.taken_valid), 64'(taken_valid));
					check_field("taken_payload", 64'(want.taken_payload),
						64'(taken_payload));
					check_field("head_valid", 64'(want.head_valid), 64'(head_valid));
					check_field("head_payload", 64'(want.head_payload),
						64'(head_payload));
					check_field("head_priority", 64'(want.head_priority),
						64'(head_priority));
					check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
					check_field("rejected", 64'(want.rejected), 64'(rejected));
				end
			end
			pending = outcomes.size();
		end
	end

endmodule

@@ test/tb_stable_priority_queue_unit.sv @@
// Testbench top for the stable priority queue unit: clock, reset, request and
// result stimulus with random gaps, watchdog and verdict.
// Depends on sprq_pkg, stable_priority_queue_unit and spq_result_checker.
module tb_stable_priority_queue_unit;
	import sprq_pkg::*;

	localparam int CNT_BITS   = $clog2(CAPACITY + 1);
	localparam int IDLE_LIMIT = 2000;
	localparam int BLOCKS     = 15;
	localparam int BLOCK_LEN  = 100;
	localparam int SETTLE     = 40;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     action;
	logic [PRIORITY_BITS-1:0] priority_req;
	logic [PAYLOAD_BITS-1:0]  payload;
	logic                     out_valid;
	logic                     out_ready;
	logic                     taken_valid;
	logic [PAYLOAD_BITS-1:0]  taken_payload;
	logic                     head_valid;
	logic [PAYLOAD_BITS-1:0]  head_payload;
	logic [PRIORITY_BITS-1:0] head_priority;
	logic [CNT_BITS-1:0]      entry_count;
	logic                     rejected;

	int fail_count;
	int pending;
	int requests;
	int checked;
	int full_rejects;
	int empty_deqs;
	int peak_fill;
	int idle_cycles;
	bit no_idle;

	stable_priority_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.priority_req  (priority_req),
		.payload       (payload),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.taken_valid   (taken_valid),
		.taken_payload (taken_payload),
		.head_valid    (head_valid),
		.head_payload  (head_payload),
		.head_priority (head_priority),
		.entry_count   (entry_count),
		.rejected      (rejected)
	);

	spq_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.priority_req  (priority_req),
		.payload       (payload),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.taken_valid   (taken_valid),
		.taken_payload (taken_payload),
		.head_valid    (head_valid),
		.head_payload  (head_payload),
		.head_priority (head_priority),
		.entry_count   (entry_count),
		.rejected      (rejected),
		.fail_count    (fail_count),
		.pending       (pending),
		.requests      (requests),
		.checked       (checked),
		.full_rejects  (full_rejects),
		.empty_deqs    (empty_deqs),
		.peak_fill     (peak_fill)
	);

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: cycles with no transaction on either channel
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: random stall before each result, none while no_idle is set
	initial begin : result_sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Offer one request transaction after a random gap; returns at the next falling edge
	task automatic send_item(input logic act, input logic [PRIORITY_BITS-1:0] pr,
			input logic [PAYLOAD_BITS-1:0] pl);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		priority_req <= pr;
		payload      <= pl;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off new requests until every predicted result has been returned
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Stimulus and verdict
	initial begin : stimulus
		int                       blk;
		int                       n;
		int                       enq_pct;
		logic                     act;
		logic [PRIORITY_BITS-1:0] pr;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_ENQ;
		priority_req = '0;
		payload      = '0;
		no_idle      = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty dequeue, extreme fields, ties, full store, FIFO drain of ties
		send_item(ACT_DEQ, '1, '1);
		send_item(ACT_ENQ, '1, '1);
		send_item(ACT_ENQ, '0, '0);
		send_item(ACT_ENQ, '0, 32'd1);
		send_item(ACT_ENQ, '1, 32'd2);
		for (n = 0; n < CAPACITY - 4; n++)
			send_item(ACT_ENQ, PRIORITY_BITS'(100 + n % 3), 32'hA5A5_0000 + n);
		send_item(ACT_ENQ, PRIORITY_BITS'(7), 32'd3);
		for (n = 0; n < 5; n++)
			send_item(ACT_DEQ, PRIORITY_BITS'($urandom), $urandom);
		drain_results();

		// Random: blocks with different enqueue bias, narrow priorities for ties
		for (blk = 0; blk < BLOCKS; blk++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0:       enq_pct = 35;
				1:       enq_pct = 50;
				2:       enq_pct = 65;
				default: enq_pct = 85;
			endcase
			if (blk == BLOCKS / 2)
				drain_results();
			for (n = 0; n < BLOCK_LEN; n++) begin
				act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
				case ($urandom_range(0, 4))
					0, 1, 2: pr = PRIORITY_BITS'($urandom_range(0, 7));
					3:       pr = PRIORITY_BITS'($urandom);
					default: pr = $urandom_range(0, 1) ? '1 : '0;
				endcase
				send_item(act, pr, $urandom);
			end
		end

		drain_results();
		repeat (SETTLE) @(negedge clk);

		$display("Sent %0d requests, checked %0d results, peak fill %0d of %0d",
			requests, checked, peak_fill, CAPACITY);
		$display("Full-store rejects %0d, dequeues on empty %0d, mismatches %0d",
			full_rejects, empty_deqs, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
